@@ rtl/round_robin_task_scheduler_macros.svh @@
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RRTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RRTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

@@ rtl/rrts_pkg.sv @@
package rrts_pkg;

	localparam int NUM_TASKS = 16;
	localparam int IDX_W     = $clog2(NUM_TASKS);
	localparam int CNT_W     = $clog2(NUM_TASKS + 1);

	localparam int REQ_W  = 3;
	localparam int TASK_W = 4;
	localparam int BCNT_W = 5;
	localparam int ST_W   = 3;
	localparam int MODE_W = 2;

	localparam logic [REQ_W-1:0] REQ_SWITCH     = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SCHEDULE   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_DESCHEDULE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_BLOCK      = 3'd3;
	localparam logic [REQ_W-1:0] REQ_UNBLOCK    = 3'd4;

	localparam logic [ST_W-1:0] ST_INACTIVE = 3'd0;
	localparam logic [ST_W-1:0] ST_READY    = 3'd1;
	localparam logic [ST_W-1:0] ST_RUNNING  = 3'd2;
	localparam logic [ST_W-1:0] ST_BLOCKED  = 3'd3;
	localparam logic [ST_W-1:0] ST_ZOMBIE   = 3'd4;

	localparam logic [MODE_W-1:0] MODE_STARTING = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RUNNING  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_IDLE     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_EXITED   = 2'd3;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [TASK_W-1:0] task_id;
	} req_t;

	typedef struct packed {
		logic [TASK_W-1:0] current_task;
		logic              idle_running;
		logic              exited;
		logic [BCNT_W-1:0] blocked_count;
		logic              accepted;
	} rsp_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_ctrl_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             full;
	} fifo_stat_t;

endpackage

@@ rtl/rrts_ready_fifo.sv @@
module rrts_ready_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rrts_pkg::fifo_ctrl_t      ctrl,
	input  logic [rrts_pkg::IDX_W-1:0] push_data,
	output logic [rrts_pkg::IDX_W-1:0] rd_data,
	output rrts_pkg::fifo_stat_t      status
);

	localparam int IDX_W = rrts_pkg::IDX_W;
	localparam int CNT_W = rrts_pkg::CNT_W;
	localparam int N     = rrts_pkg::NUM_TASKS;

	logic [IDX_W-1:0] mem [N];
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W:0]   tail_sum;
	logic [CNT_W:0]   tail_wrap;
	logic [IDX_W-1:0] tail;
	logic             full;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q >= CNT_W'(N));
	assign tail_sum  = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
	assign tail_wrap = (tail_sum >= (CNT_W+1)'(N)) ? tail_sum - (CNT_W+1)'(N) : tail_sum;
	assign tail      = tail_wrap[IDX_W-1:0];
	assign do_push   = ctrl.push && !full;
	assign do_pop    = ctrl.pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[tail] <= push_data;
		end
		if (do_pop) begin
			rd_data <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_pop) begin
				head_q <= (head_q == IDX_W'(N - 1)) ? '0 : head_q + 1'b1;
			end
			// pushes and pops never share a cycle under the sequencer
			if (do_push) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign status.count = count_q;
	assign status.full  = full;

endmodule

@@ rtl/round_robin_task_scheduler.sv @@
// Round-robin ready-queue scheduler, one request at a time.
// Schedule/deschedule/block/unblock pass through S_EXEC and then S_RESP; an ignored
// request goes straight to S_RESP. A switch passes S_PREV, then S_POP and S_CHECK for
// each dequeue (up to NUM_TASKS), and ends in S_RESP once it runs a task, or after a
// last S_POP when the queue runs dry. The state table has a single read port.
// A new request is taken only while busy is low; the receiver cannot stall.
`include "round_robin_task_scheduler_macros.svh"

module round_robin_task_scheduler (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  rrts_pkg::req_t request,
	output logic           busy,
	output logic           done,
	output rrts_pkg::rsp_t result
);

	// Reset (arst_n low): all tasks inactive, queue empty, mode starting.

	localparam int N      = rrts_pkg::NUM_TASKS;
	localparam int IDX_W  = rrts_pkg::IDX_W;
	localparam int CNT_W  = rrts_pkg::CNT_W;
	localparam int ST_W   = rrts_pkg::ST_W;
	localparam int MODE_W = rrts_pkg::MODE_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_PREV  = 3'd2;
	localparam logic [2:0] S_POP   = 3'd3;
	localparam logic [2:0] S_CHECK = 3'd4;
	localparam logic [2:0] S_RESP  = 3'd5;

	logic [2:0]                   seq_q;
	logic [rrts_pkg::REQ_W-1:0]   req_q;
	logic [IDX_W-1:0]             addr_q;
	logic [ST_W-1:0]              state_q [N];
	logic [N-1:0]                 inq_q;
	logic [CNT_W-1:0]             btot_q;
	logic [IDX_W-1:0]             running_q;
	logic [MODE_W-1:0]            mode_q;
	logic                         acc_q;

	rrts_pkg::fifo_ctrl_t         fifo_ctrl;
	rrts_pkg::fifo_stat_t         fifo_stat;
	logic [IDX_W-1:0]             fifo_rd;
	logic [IDX_W-1:0]             rd_addr;
	logic [ST_W-1:0]              st_rd;
	logic                         absent;
	logic                         push_req;
	logic                         enq;
	logic                         tid_ok;
	logic                         req_ok;

	rrts_ready_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (fifo_ctrl),
		.push_data (addr_q),
		.rd_data   (fifo_rd),
		.status    (fifo_stat)
	);

	// one read port on the state table, steered by the sequencer
	assign rd_addr = (seq_q == S_CHECK) ? fifo_rd : addr_q;
	assign st_rd   = state_q[rd_addr];
	assign absent  = !inq_q[addr_q];
	assign tid_ok  = (32'(request.task_id) < N);
	assign req_ok  = (request.req_type == rrts_pkg::REQ_SCHEDULE) ||
	                 (request.req_type == rrts_pkg::REQ_DESCHEDULE) ||
	                 (request.req_type == rrts_pkg::REQ_BLOCK) ||
	                 (request.req_type == rrts_pkg::REQ_UNBLOCK);

	always_comb begin
		push_req = 1'b0;
		if (seq_q == S_EXEC) begin
			unique case (req_q)
				rrts_pkg::REQ_SCHEDULE:   push_req = absent;
				rrts_pkg::REQ_DESCHEDULE: push_req = absent && (st_rd != rrts_pkg::ST_RUNNING);
				rrts_pkg::REQ_UNBLOCK:    push_req = absent && (st_rd == rrts_pkg::ST_BLOCKED);
				default:                  push_req = 1'b0;
			endcase
		end else if (seq_q == S_PREV) begin
			push_req = absent && (mode_q == rrts_pkg::MODE_RUNNING) &&
			           (st_rd == rrts_pkg::ST_RUNNING);
		end
		enq = push_req && !fifo_stat.full;
		fifo_ctrl.push = enq;
		fifo_ctrl.pop  = (seq_q == S_POP) && (fifo_stat.count != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q     <= S_IDLE;
			req_q     <= rrts_pkg::REQ_SWITCH;
			addr_q    <= '0;
			inq_q     <= '0;
			btot_q    <= '0;
			running_q <= '0;
			mode_q    <= rrts_pkg::MODE_STARTING;
			acc_q     <= 1'b0;
			for (int i = 0; i < N; i++) begin
				state_q[i] <= rrts_pkg::ST_INACTIVE;
			end
		end else begin
			if (enq) begin
				inq_q[addr_q] <= 1'b1;
			end
			unique case (seq_q)
				S_IDLE: begin
					acc_q <= 1'b0;
					if (start) begin
						req_q <= request.req_type;
						if (request.req_type == rrts_pkg::REQ_SWITCH) begin
							addr_q <= running_q;
							seq_q  <= S_PREV;
						end else if (req_ok && tid_ok) begin
							addr_q <= IDX_W'(request.task_id);
							seq_q  <= S_EXEC;
						end else begin
							seq_q <= S_RESP;
						end
					end
				end
				S_EXEC: begin
					seq_q <= S_RESP;
					unique case (req_q)
						rrts_pkg::REQ_SCHEDULE: begin
							if (absent) begin
								if (st_rd == rrts_pkg::ST_BLOCKED && btot_q != '0) begin
									btot_q <= btot_q - 1'b1;
								end
								state_q[addr_q] <= rrts_pkg::ST_READY;
								acc_q <= 1'b1;
							end
						end
						rrts_pkg::REQ_DESCHEDULE: begin
							if (st_rd == rrts_pkg::ST_BLOCKED && btot_q != '0) begin
								btot_q <= btot_q - 1'b1;
							end
							state_q[addr_q] <= (st_rd == rrts_pkg::ST_RUNNING) ?
							                   rrts_pkg::ST_INACTIVE : rrts_pkg::ST_ZOMBIE;
							acc_q <= 1'b1;
						end
						rrts_pkg::REQ_BLOCK: begin
							if (st_rd == rrts_pkg::ST_READY || st_rd == rrts_pkg::ST_RUNNING) begin
								state_q[addr_q] <= rrts_pkg::ST_BLOCKED;
								btot_q <= btot_q + 1'b1;
								acc_q <= 1'b1;
							end
						end
						rrts_pkg::REQ_UNBLOCK: begin
							if (st_rd == rrts_pkg::ST_BLOCKED) begin
								if (btot_q != '0) begin
									btot_q <= btot_q - 1'b1;
								end
								state_q[addr_q] <= rrts_pkg::ST_READY;
								acc_q <= 1'b1;
							end
						end
						default: begin
							acc_q <= 1'b0;
						end
					endcase
				end
				S_PREV: begin
					// requeue or retire the previous task
					acc_q <= 1'b1;
					seq_q <= S_POP;
					if (mode_q == rrts_pkg::MODE_RUNNING) begin
						if (st_rd == rrts_pkg::ST_RUNNING) begin
							state_q[addr_q] <= rrts_pkg::ST_READY;
						end else if (st_rd == rrts_pkg::ST_ZOMBIE) begin
							state_q[addr_q] <= rrts_pkg::ST_INACTIVE;
						end
					end
				end
				S_POP: begin
					if (fifo_stat.count == '0) begin
						mode_q <= (btot_q == '0) ? rrts_pkg::MODE_EXITED : rrts_pkg::MODE_IDLE;
						seq_q  <= S_RESP;
					end else begin
						seq_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					inq_q[fifo_rd] <= 1'b0;
					if (st_rd == rrts_pkg::ST_ZOMBIE) begin
						state_q[fifo_rd] <= rrts_pkg::ST_INACTIVE;
						seq_q <= S_POP;
					end else if (st_rd == rrts_pkg::ST_BLOCKED) begin
						// drop stale entry
						seq_q <= S_POP;
					end else begin
						state_q[fifo_rd] <= rrts_pkg::ST_RUNNING;
						running_q <= fifo_rd;
						mode_q    <= rrts_pkg::MODE_RUNNING;
						seq_q     <= S_RESP;
					end
				end
				S_RESP: begin
					seq_q <= S_IDLE;
				end
				default: begin
					seq_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (seq_q != S_IDLE);
	assign done = (seq_q == S_RESP);

	assign result.current_task  = (mode_q == rrts_pkg::MODE_RUNNING) ?
	                              rrts_pkg::TASK_W'(running_q) : '0;
	assign result.idle_running  = (mode_q == rrts_pkg::MODE_IDLE);
	assign result.exited        = (mode_q == rrts_pkg::MODE_EXITED);
	assign result.blocked_count = rrts_pkg::BCNT_W'(btot_q);
	assign result.accepted      = acc_q;

	`RRTS_ASSERT_NEXT(a_done_frees, done, !busy)
	`RRTS_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	`RRTS_ASSERT_NOW(a_btot_range, 1'b1, btot_q <= CNT_W'(N))
	`RRTS_ASSERT_NOW(a_fifo_range, 1'b1, fifo_stat.count <= CNT_W'(N))
	`RRTS_ASSERT_NOW(a_no_push_pop, fifo_ctrl.push, !fifo_ctrl.pop)

endmodule
